### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every edge, reset included.
`define FLSC_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("flsc check failed");

// Checked only while out of reset.
`define FLSC_ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("flsc check failed");

`endif

### hdl/flsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package flsc_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int PWM_TOP_DEF     = 24999;

    localparam int CMD_W      = 2;
    localparam int TEMP_W     = 6;
    localparam int LEVEL_W    = 15;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam int TEMP_OFFSET = 20;
    localparam int QUEUE_DEPTH = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRESS  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_OFF = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_LOW = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_MID = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_LOW     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MID     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_HIGH    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TIME = 4'd7;

    // register reset values
    localparam logic [TEMP_W-1:0]  RST_THRESHOLD_OFF = 6'd20;
    localparam logic [TEMP_W-1:0]  RST_THRESHOLD_LOW = 6'd25;
    localparam logic [TEMP_W-1:0]  RST_THRESHOLD_MID = 6'd30;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_LOW     = 15'd5000;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_MID     = 15'd15000;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_HIGH    = 15'd24900;
    localparam logic [LEVEL_W-1:0] RST_RAMP_STEP     = 15'd100;
    localparam logic [TIME_W-1:0]  RST_DEBOUNCE_TIME = 32'd300000;

    typedef struct packed {
        logic [TEMP_W-1:0]  threshold_off;
        logic [TEMP_W-1:0]  threshold_low;
        logic [TEMP_W-1:0]  threshold_mid;
        logic [LEVEL_W-1:0] level_low;
        logic [LEVEL_W-1:0] level_mid;
        logic [LEVEL_W-1:0] level_high;
        logic [LEVEL_W-1:0] ramp_step;
        logic [TIME_W-1:0]  debounce_time;
    } cfg_t;

    // classified word passed from front to back
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [TEMP_W-1:0]  temp;
        logic [LEVEL_W-1:0] target;
        logic [TIME_W-1:0]  time_us;
    } item_t;

endpackage

`default_nettype wire

### hdl/flsc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module flsc_front import flsc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int PWM_TOP     = PWM_TOP_DEF
) (
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [CMD_W-1:0]       command,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic [TIME_W-1:0]      time_us,
    input  wire cfg_t                   cfg,
    input  wire logic                   q_full,
    output logic                        q_push,
    output item_t                       q_item
);

    localparam int SW = SAMPLE_BITS + 6;
    localparam logic [LEVEL_W+1:0] TOP = (LEVEL_W + 2)'(PWM_TOP);

    logic [SW-1:0]      s_ext;
    logic [SW-1:0]      scaled;
    logic [TEMP_W-1:0]  temp;
    logic [LEVEL_W-1:0] level_raw;
    logic [LEVEL_W-1:0] level_sat;

    // 15*s + 20*2^SB, then keep the integer part
    assign s_ext  = SW'(sample);
    assign scaled = (s_ext << 4) - s_ext + (SW'(TEMP_OFFSET) << SAMPLE_BITS);
    assign temp   = scaled[SAMPLE_BITS +: TEMP_W];

    // thresholds tested in order off, low, mid
    always_comb
    begin
        if (temp <= cfg.threshold_low)
        begin
            level_raw = cfg.level_low;
        end
        else if (temp <= cfg.threshold_mid)
        begin
            level_raw = cfg.level_mid;
        end
        else
        begin
            level_raw = cfg.level_high;
        end
    end

    always_comb
    begin
        if ({2'b00, level_raw} > TOP)
        begin
            level_sat = TOP[LEVEL_W-1:0];
        end
        else
        begin
            level_sat = level_raw;
        end
    end

    assign in_stall       = q_full;
    assign q_push         = in_valid && !q_full;
    assign q_item.cmd     = command;
    assign q_item.temp    = temp;
    assign q_item.target  = (temp <= cfg.threshold_off) ? '0 : level_sat;
    assign q_item.time_us = time_us;

endmodule

`default_nettype wire

### hdl/flsc_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module flsc_queue import flsc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output logic       full,
    output logic       q_valid,
    output item_t      head
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full    = (count_reg == CW'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

`include "assert_macros.svh"

    `FLSC_ASSERT_RST(a_count_bound, clk, rst_n, count_reg <= CW'(QUEUE_DEPTH))
    `FLSC_ASSERT_RST(a_pop_nonempty, clk, rst_n, pop |-> count_reg != '0)

endmodule

`default_nettype wire

### hdl/flsc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module flsc_back import flsc_pkg::*; (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire cfg_t          cfg,
    input  wire logic          q_valid,
    input  wire item_t         item,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [LEVEL_W-1:0] pwm_level,
    output logic               enabled,
    output logic               ramping,
    output logic [TEMP_W-1:0]  temperature
);

    logic [LEVEL_W-1:0] cur_reg, cur_next;
    logic [LEVEL_W-1:0] tgt_reg, tgt_next;
    logic               en_reg, en_next;
    logic [TIME_W-1:0]  last_press_reg, last_press_next;
    logic [TEMP_W-1:0]  temp_reg, temp_next;
    logic               out_valid_reg, out_valid_next;

    logic [LEVEL_W-1:0] pwm_level_reg;
    logic               enabled_reg;
    logic               ramping_reg;
    logic [TEMP_W-1:0]  temperature_reg;

    logic               take;
    logic [LEVEL_W:0]   sum;
    logic [LEVEL_W-1:0] gap;
    logic [TIME_W-1:0]  elapsed;

    // take a word whenever the output register is free or being drained
    assign take  = q_valid && (!out_valid_reg || !out_stall);
    assign q_pop = take;

    assign sum     = {1'b0, cur_reg} + {1'b0, cfg.ramp_step};
    assign gap     = cur_reg - tgt_reg;
    assign elapsed = item.time_us - last_press_reg;

    always_comb
    begin
        cur_next        = cur_reg;
        tgt_next        = tgt_reg;
        en_next         = en_reg;
        last_press_next = last_press_reg;
        temp_next       = temp_reg;
        if (take)
        begin
            case (item.cmd)
                CMD_SAMPLE:
                begin
                    // dropped while disabled or mid-ramp
                    if (en_reg && (cur_reg == tgt_reg))
                    begin
                        tgt_next  = item.target;
                        temp_next = item.temp;
                    end
                end
                CMD_TICK:
                begin
                    if (cur_reg < tgt_reg)
                    begin
                        cur_next = (sum > {1'b0, tgt_reg}) ? tgt_reg : sum[LEVEL_W-1:0];
                    end
                    else if (cur_reg > tgt_reg)
                    begin
                        cur_next = (cfg.ramp_step >= gap) ? tgt_reg
                                                          : cur_reg - cfg.ramp_step;
                    end
                end
                CMD_PRESS:
                begin
                    if (elapsed >= cfg.debounce_time)
                    begin
                        last_press_next = item.time_us;
                        en_next         = !en_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            tgt_reg        <= '0;
            en_reg         <= 1'b1;
            last_press_reg <= '0;
            temp_reg       <= TEMP_W'(TEMP_OFFSET);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_reg        <= cur_next;
            tgt_reg        <= tgt_next;
            en_reg         <= en_next;
            last_press_reg <= last_press_next;
            temp_reg       <= temp_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pwm_level_reg   <= cur_next;
            enabled_reg     <= en_next;
            ramping_reg     <= (cur_next != tgt_next);
            temperature_reg <= temp_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pwm_level   = pwm_level_reg;
    assign enabled     = enabled_reg;
    assign ramping     = ramping_reg;
    assign temperature = temperature_reg;

`include "assert_macros.svh"

    `FLSC_ASSERT_RST(a_tick_keeps_target, clk, rst_n,
        take && item.cmd == CMD_TICK |=> $stable(tgt_reg))
    `FLSC_ASSERT_RST(a_tick_no_overshoot, clk, rst_n,
        take && item.cmd == CMD_TICK && cur_reg <= tgt_reg |=> cur_reg <= tgt_reg)
    `FLSC_ASSERT_RST(a_sample_held_off, clk, rst_n,
        take && item.cmd == CMD_SAMPLE && cur_reg != tgt_reg |=>
            $stable(tgt_reg) && $stable(temp_reg))

endmodule

`default_nettype wire

### hdl/fan_level_slew_controller.sv
// Fan level slew controller.
// Input channel (in_valid / in_stall) takes one word per cycle unless stalled:
// command 0 is a converter sample that sets a new target level from the derived
// temperature, command 1 a ramp tick that moves the output one step toward the
// target, command 2 a button press that toggles enable after the debounce time.
// Every input word yields exactly one result word on the output channel
// (out_valid / out_stall): pwm_level, enabled, ramping and temperature.
// An accepted word is written into the queue, taken from its head by the back
// end and held in the output register, offered on the output until taken.
// Throughput: one word per cycle while out_stall is low; the back end updates
// its state as it takes a word, so only the output handshake limits the rate.
// A stalled output holds its word; the two-entry queue between the front
// classifier and the back end absorbs the stall, and in_stall rises once the
// queue is full. Configuration writes (cfg_valid / cfg_ready, always ready)
// are meant for idle periods; unknown indexes are dropped.
// Reset clears the output level and target to zero, sets enable, restores the
// register defaults and empties the queue and output register.
`timescale 1ns / 1ps
`default_nettype none

module fan_level_slew_controller import flsc_pkg::*; #(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int PWM_TOP     = PWM_TOP_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // input channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [CMD_W-1:0]       command,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic [TIME_W-1:0]      time_us,
    // output channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [LEVEL_W-1:0]          pwm_level,
    output logic                        enabled,
    output logic                        ramping,
    output logic [TEMP_W-1:0]           temperature,
    // configuration write channel
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_valid;
    item_t push_item;
    item_t head;

    // register file: always ready, writes are registered
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_THRESHOLD_OFF: cfg_next.threshold_off = cfg_data[TEMP_W-1:0];
                REG_THRESHOLD_LOW: cfg_next.threshold_low = cfg_data[TEMP_W-1:0];
                REG_THRESHOLD_MID: cfg_next.threshold_mid = cfg_data[TEMP_W-1:0];
                REG_LEVEL_LOW:     cfg_next.level_low     = cfg_data[LEVEL_W-1:0];
                REG_LEVEL_MID:     cfg_next.level_mid     = cfg_data[LEVEL_W-1:0];
                REG_LEVEL_HIGH:    cfg_next.level_high    = cfg_data[LEVEL_W-1:0];
                REG_RAMP_STEP:     cfg_next.ramp_step     = cfg_data[LEVEL_W-1:0];
                REG_DEBOUNCE_TIME: cfg_next.debounce_time = cfg_data[TIME_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold_off <= RST_THRESHOLD_OFF;
            cfg_reg.threshold_low <= RST_THRESHOLD_LOW;
            cfg_reg.threshold_mid <= RST_THRESHOLD_MID;
            cfg_reg.level_low     <= RST_LEVEL_LOW;
            cfg_reg.level_mid     <= RST_LEVEL_MID;
            cfg_reg.level_high    <= RST_LEVEL_HIGH;
            cfg_reg.ramp_step     <= RST_RAMP_STEP;
            cfg_reg.debounce_time <= RST_DEBOUNCE_TIME;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front: accept and classify (temperature, saturated target level)
    flsc_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .PWM_TOP     (PWM_TOP)
    ) u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .command  (command),
        .sample   (sample),
        .time_us  (time_us),
        .cfg      (cfg_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    // short queue decouples front from back
    flsc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .full      (q_full),
        .q_valid   (q_valid),
        .head      (head)
    );

    // back: state update (target, ramp, enable toggle) and output register
    flsc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_valid     (q_valid),
        .item        (head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pwm_level   (pwm_level),
        .enabled     (enabled),
        .ramping     (ramping),
        .temperature (temperature)
    );

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import flsc_pkg::*;

    // Command 3 has no code in the package; the block must treat it as a no-op.
    localparam logic [CMD_W-1:0]     CMD_UNUSED   = 2'd3;
    // Indexes past the last register, which writes must leave alone.
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO  = 4'd8;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI  = 4'd15;
    localparam int                   PIPE_LATENCY = 2;
    localparam int                   MAX_REPORTS  = 10;

    typedef struct packed {
        logic [LEVEL_W-1:0] pwm_level;
        logic               enabled;
        logic               ramping;
        logic [TEMP_W-1:0]  temperature;
    } fan_result_t;

    // Every input of the block holds a known value from time zero.
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic [CMD_W-1:0]           command   = CMD_TICK;
    logic [SAMPLE_BITS_DEF-1:0] sample    = '0;
    logic [TIME_W-1:0]          time_us   = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [LEVEL_W-1:0]         pwm_level;
    logic                       enabled;
    logic                       ramping;
    logic [TEMP_W-1:0]          temperature;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;

    // Predictor copy of the registers and the fan state.
    cfg_t                       fan_cfg;
    logic [LEVEL_W-1:0]         fan_level;
    logic [LEVEL_W-1:0]         fan_target;
    logic                       fan_enable;
    logic [TIME_W-1:0]          fan_last_press;
    logic [TEMP_W-1:0]          fan_temp;

    // Results owed by the block, oldest first.
    fan_result_t                owed_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles   = 0;
    int mismatches    = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int reg_writes    = 0;

    fan_level_slew_controller u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .sample      (sample),
        .time_us     (time_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pwm_level   (pwm_level),
        .enabled     (enabled),
        .ramping     (ramping),
        .temperature (temperature),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void reset_fan_model();
        fan_cfg.threshold_off = RST_THRESHOLD_OFF;
        fan_cfg.threshold_low = RST_THRESHOLD_LOW;
        fan_cfg.threshold_mid = RST_THRESHOLD_MID;
        fan_cfg.level_low     = RST_LEVEL_LOW;
        fan_cfg.level_mid     = RST_LEVEL_MID;
        fan_cfg.level_high    = RST_LEVEL_HIGH;
        fan_cfg.ramp_step     = RST_RAMP_STEP;
        fan_cfg.debounce_time = RST_DEBOUNCE_TIME;
        fan_level      = '0;
        fan_target     = '0;
        fan_enable     = 1'b1;
        fan_last_press = '0;
        fan_temp       = TEMP_W'(TEMP_OFFSET);
    endfunction

    // Register write as the block should see it; data wider than the
    // register is cut to its width, unknown indexes do nothing.
    function automatic void write_fan_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_THRESHOLD_OFF: fan_cfg.threshold_off = data[TEMP_W-1:0];
            REG_THRESHOLD_LOW: fan_cfg.threshold_low = data[TEMP_W-1:0];
            REG_THRESHOLD_MID: fan_cfg.threshold_mid = data[TEMP_W-1:0];
            REG_LEVEL_LOW:     fan_cfg.level_low     = data[LEVEL_W-1:0];
            REG_LEVEL_MID:     fan_cfg.level_mid     = data[LEVEL_W-1:0];
            REG_LEVEL_HIGH:    fan_cfg.level_high    = data[LEVEL_W-1:0];
            REG_RAMP_STEP:     fan_cfg.ramp_step     = data[LEVEL_W-1:0];
            REG_DEBOUNCE_TIME: fan_cfg.debounce_time = data[TIME_W-1:0];
            default: ;
        endcase
    endfunction

    // (15 * raw + 20 * 2^bits) / 2^bits, which lands in 20..34.
    function automatic logic [TEMP_W-1:0] raw_to_temp(input logic [SAMPLE_BITS_DEF-1:0] raw);
        logic [31:0] scaled;
        scaled = (32'd15 * 32'(raw) + (32'(TEMP_OFFSET) << SAMPLE_BITS_DEF))
                 >> SAMPLE_BITS_DEF;
        return scaled[TEMP_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] clamp_to_top(input logic [LEVEL_W-1:0] lvl);
        return (32'(lvl) > PWM_TOP_DEF) ? LEVEL_W'(PWM_TOP_DEF) : lvl;
    endfunction

    // Advance the fan state by one accepted word and return the result word.
    function automatic fan_result_t advance_fan(input logic [CMD_W-1:0] cmd,
                                                input logic [SAMPLE_BITS_DEF-1:0] raw,
                                                input logic [TIME_W-1:0] stamp);
        logic [31:0]       next_level;
        logic [31:0]       gap;
        logic [TIME_W-1:0] elapsed;
        logic [TEMP_W-1:0] t;
        fan_result_t       res;
        case (cmd)
            CMD_SAMPLE:
            begin
                // dropped while disabled or mid-ramp
                if (fan_enable && fan_level == fan_target)
                begin
                    t = raw_to_temp(raw);
                    fan_temp = t;
                    // first matching threshold wins, even if out of order
                    if (t <= fan_cfg.threshold_off)
                        fan_target = '0;
                    else if (t <= fan_cfg.threshold_low)
                        fan_target = clamp_to_top(fan_cfg.level_low);
                    else if (t <= fan_cfg.threshold_mid)
                        fan_target = clamp_to_top(fan_cfg.level_mid);
                    else
                        fan_target = clamp_to_top(fan_cfg.level_high);
                end
            end
            CMD_TICK:
            begin
                if (fan_level < fan_target)
                begin
                    next_level = 32'(fan_level) + 32'(fan_cfg.ramp_step);
                    fan_level = (next_level > 32'(fan_target)) ? fan_target
                                                               : next_level[LEVEL_W-1:0];
                end
                else if (fan_level > fan_target)
                begin
                    gap = 32'(fan_level) - 32'(fan_target);
                    fan_level = (32'(fan_cfg.ramp_step) >= gap) ? fan_target
                                                                 : fan_level - fan_cfg.ramp_step;
                end
            end
            CMD_PRESS:
            begin
                elapsed = stamp - fan_last_press;   // wraps mod 2^32
                if (elapsed >= fan_cfg.debounce_time)
                begin
                    fan_last_press = stamp;
                    fan_enable = ~fan_enable;
                end
            end
            default: ;
        endcase
        res.pwm_level   = fan_level;
        res.enabled     = fan_enable;
        res.ramping     = (fan_level != fan_target);
        res.temperature = fan_temp;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall pattern and result check
    // ------------------------------------------------------------------

    // A pending hold forces stall for that many cycles; otherwise random.
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles = hold_cycles - 1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Outputs are read at the edge, before the block's own updates land,
    // so the values seen are the ones the handshake closes on.
    always @(posedge clk)
    begin : check_results
        fan_result_t got;
        fan_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.pwm_level   = pwm_level;
            got.enabled     = enabled;
            got.ramping     = ramping;
            got.temperature = temperature;
            if (owed_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result word: level=%0d en=%0b ramp=%0b temp=%0d",
                             got.pwm_level, got.enabled, got.ramping, got.temperature);
            end
            else
            begin
                want = owed_results.pop_front();
                if (got.pwm_level !== want.pwm_level || got.enabled !== want.enabled ||
                    got.ramping !== want.ramping || got.temperature !== want.temperature)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("word %0d mismatch: exp level=%0d en=%0b ramp=%0b temp=%0d",
                                 words_checked, want.pwm_level, want.enabled,
                                 want.ramping, want.temperature,
                                 "  got level=%0d en=%0b ramp=%0b temp=%0d",
                                 got.pwm_level, got.enabled, got.ramping, got.temperature);
                end
                words_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word, with random gaps ahead of it, and predict it once taken.
    task automatic send_word(input logic [CMD_W-1:0] cmd,
                             input logic [SAMPLE_BITS_DEF-1:0] raw,
                             input logic [TIME_W-1:0] stamp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        sample   <= raw;
        time_us  <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        owed_results.push_back(advance_fan(cmd, raw, stamp));
        words_sent++;
    endtask

    // Stop offering and wait until every owed result is in, then a bit more.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // Only called with the block drained.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        write_fan_reg(idx, data);
        reg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sometimes set bits above the register width; the block must drop them.
    function automatic logic [CFG_DATA_W-1:0] with_junk(input logic [CFG_DATA_W-1:0] val,
                                                        input int width);
        logic [CFG_DATA_W-1:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom()) : '0;
        return (width >= CFG_DATA_W) ? val : ((junk << width) | val);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(PWM_TOP_DEF + 1, 32767);   // saturates
            2:       return PWM_TOP_DEF;
            default: return $urandom_range(0, PWM_TOP_DEF);
        endcase
    endfunction

    task automatic shuffle_registers();
        logic [CFG_DATA_W-1:0] th [3];
        logic [CFG_DATA_W-1:0] swap;
        logic [CFG_DATA_W-1:0] step;
        logic [CFG_DATA_W-1:0] debounce;
        drain_results();
        foreach (th[i])
            th[i] = $urandom_range(20, 35);
        // mostly ordered thresholds, the rest left as drawn
        if ($urandom_range(0, 9) < 7)
        begin
            if (th[0] > th[1]) begin swap = th[0]; th[0] = th[1]; th[1] = swap; end
            if (th[1] > th[2]) begin swap = th[1]; th[1] = th[2]; th[2] = swap; end
            if (th[0] > th[1]) begin swap = th[0]; th[0] = th[1]; th[1] = swap; end
        end
        case ($urandom_range(0, 19))
            0:       step = 0;
            1:       step = 32767;
            2, 3:    step = $urandom_range(1, 50);
            default: step = $urandom_range(500, PWM_TOP_DEF);
        endcase
        case ($urandom_range(0, 9))
            0:       debounce = 0;
            1:       debounce = 32'hFFFF_FFFF;
            2, 3:    debounce = $urandom();
            default: debounce = $urandom_range(1, 1000000);
        endcase
        write_reg(REG_THRESHOLD_OFF, with_junk(th[0], TEMP_W));
        write_reg(REG_THRESHOLD_LOW, with_junk(th[1], TEMP_W));
        write_reg(REG_THRESHOLD_MID, with_junk(th[2], TEMP_W));
        write_reg(REG_LEVEL_LOW,     with_junk(pick_level(), LEVEL_W));
        write_reg(REG_LEVEL_MID,     with_junk(pick_level(), LEVEL_W));
        write_reg(REG_LEVEL_HIGH,    with_junk(pick_level(), LEVEL_W));
        write_reg(REG_RAMP_STEP,     with_junk(step, LEVEL_W));
        write_reg(REG_DEBOUNCE_TIME, debounce);
        if ($urandom_range(0, 3) == 0)
            write_reg(CFG_IDX_W'($urandom_range(REG_NONE_LO, REG_NONE_HI)), $urandom());
    endtask

    // Mostly ticks and samples, so ramps finish and new targets get taken;
    // presses cluster around the debounce boundary.
    task automatic send_random_word();
        int                         pick;
        logic [SAMPLE_BITS_DEF-1:0] raw;
        logic [TIME_W-1:0]          stamp;
        pick  = $urandom_range(0, 99);
        raw   = SAMPLE_BITS_DEF'($urandom());
        stamp = $urandom();
        if (pick < 45)
            send_word(CMD_TICK, raw, stamp);
        else if (pick < 75)
        begin
            case ($urandom_range(0, 7))
                0:       raw = '0;
                1:       raw = '1;
                default: ;
            endcase
            send_word(CMD_SAMPLE, raw, stamp);
        end
        else if (pick < 93)
        begin
            case ($urandom_range(0, 4))
                0:       stamp = fan_last_press + fan_cfg.debounce_time - 1;
                1:       stamp = fan_last_press + fan_cfg.debounce_time;
                2, 3:    stamp = fan_last_press + fan_cfg.debounce_time
                                 + $urandom_range(0, 5000);
                default: ;
            endcase
            send_word(CMD_PRESS, raw, stamp);
        end
        else
            send_word(CMD_UNUSED, raw, stamp);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset values, unused command, ignored samples, debounce and its wrap.
    task automatic test_reset_behavior();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_word(CMD_UNUSED, '1, '1);            // no-op, reports reset state
        send_word(CMD_TICK, '0, '0);              // already at target
        send_word(CMD_SAMPLE, '0, '1);            // 20 degC, at off threshold
        send_word(CMD_SAMPLE, '1, '0);            // 34 degC, high level
        send_word(CMD_SAMPLE, 12'd2048, '0);      // ignored, still ramping
        send_word(CMD_TICK, '1, '1);
        send_word(CMD_PRESS, '0, 32'd0);          // too soon after reset
        send_word(CMD_PRESS, '0, 32'd300000);     // exactly debounce: taken
        send_word(CMD_PRESS, '0, 32'd299999);     // wraps to a huge gap: taken
        send_word(CMD_PRESS, '0, 32'd300000);     // one us later: rejected
        drain_results();
    endtask

    // Overshoot, saturation, unordered thresholds, zero step, debounce ends,
    // writes to unknown indexes.
    task automatic test_ramp_extremes();
        write_reg(REG_RAMP_STEP, 32'hFFFF_FFFF);  // masks to 32767
        write_reg(REG_LEVEL_HIGH, 32'h0000_7FFF);
        send_word(CMD_TICK, '0, '0);              // clamps at target
        send_word(CMD_SAMPLE, '1, '0);            // high level saturates to top
        send_word(CMD_TICK, '0, '0);
        drain_results();
        write_reg(REG_THRESHOLD_OFF, 32'd35);
        write_reg(REG_THRESHOLD_LOW, 32'd20);
        write_reg(REG_THRESHOLD_MID, 32'd20);
        send_word(CMD_SAMPLE, '1, '0);            // off wins first
        send_word(CMD_TICK, '0, '0);              // downward clamp to zero
        drain_results();
        write_reg(REG_THRESHOLD_OFF, 32'd20);
        write_reg(REG_THRESHOLD_LOW, 32'd35);
        write_reg(REG_THRESHOLD_MID, 32'd25);
        write_reg(REG_LEVEL_LOW, 32'h0000_7FFF);
        write_reg(REG_LEVEL_MID, 32'd0);
        write_reg(REG_RAMP_STEP, 32'd0);
        send_word(CMD_SAMPLE, 12'd2048, '0);      // 27 degC, low level
        send_word(CMD_TICK, '0, '0);              // zero step: no movement
        drain_results();
        write_reg(REG_RAMP_STEP, PWM_TOP_DEF);
        write_reg(REG_DEBOUNCE_TIME, 32'hFFFF_FFFF);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_PRESS, '0, fan_last_press - 1);   // gap of all ones: taken
        send_word(CMD_SAMPLE, '1, '0);                  // disabled: ignored
        send_word(CMD_PRESS, '0, fan_last_press);       // zero gap: rejected
        drain_results();
        write_reg(REG_DEBOUNCE_TIME, 32'd0);
        write_reg(REG_NONE_LO, 32'hFFFF_FFFF);
        write_reg(REG_NONE_HI, 32'd0);
        send_word(CMD_PRESS, '0, fan_last_press);       // zero debounce: taken
        send_word(CMD_UNUSED, '0, '0);
        drain_results();
    endtask

    // Hold the output off long enough that the queue fills and in_stall rises
    // while the sender keeps offering.
    task automatic test_stall_fill();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(REG_RAMP_STEP, 32'd1000);
        hold_cycles = 40;
        repeat (14) send_random_word();
        drain_results();
    endtask

    task automatic test_random_phase(input int sender_gap_pct, input int receiver_gap_pct);
        send_idle_pct = sender_gap_pct;
        recv_idle_pct = receiver_gap_pct;
        repeat (4)
        begin
            shuffle_registers();
            repeat (50) send_random_word();
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        reset_fan_model();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_behavior();
        test_ramp_extremes();
        test_stall_fill();
        test_random_phase(26, 63);
        test_random_phase(63, 26);
        test_random_phase(0, 0);
        drain_results();
        $display("run covered %0d input words (%0d results checked) and %0d register writes",
                 words_sent, words_checked, reg_writes);
        $display("under three gap profiles, a long output hold and register extremes");
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still owed", owed_results.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule
